// File: rtl/sdrp_pkg.sv
// Shared types, constants and the CRC-8 byte step for the setting detail
// response parser. No dependencies.
`default_nettype none

package sdrp_pkg;

  // Frame layout and protocol constants
  localparam int unsigned MaxFrameDefault = 32;
  localparam logic [7:0]  CrcPoly         = 8'hD5;
  localparam logic [7:0]  FrameHeader     = 8'hCC;
  localparam logic [7:0]  TypeString      = 8'd10;
  localparam int unsigned MinLen          = 5;
  localparam int unsigned KindIndex       = 3;
  localparam int unsigned TermStartIndex  = 4;

  // Status codes
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusTooShort  = 3'd1;
  localparam logic [2:0] StatusBadHeader = 3'd2;
  localparam logic [2:0] StatusNotString = 3'd3;
  localparam logic [2:0] StatusNoTerm    = 3'd4;
  localparam logic [2:0] StatusNoSize    = 3'd5;

  // One parse result
  typedef struct packed {
    logic [5:0] frame_length;
    logic [7:0] size_limit;
    logic [7:0] setting_kind;
    logic       crc_ok;
    logic [2:0] status;
  } result_t;

  // CRC-8, MSB first, no reflection, no final xor: one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/setting_detail_response_parser.sv
// Top level of the setting detail response parser: input register, frame
// tracker and result register. Depends on sdrp_pkg, sdrp_frame_state, sdrp_out_reg.
//
//  Channel  Dir  Payload                               Transfer
//  s_axis   in   tdata[7:0] data_byte, tlast final     one per response byte
//  m_axis   out  tdata status..frame_length (26 bits)  one per frame, on final byte
//
// One byte per cycle sustained, save that a final byte waits while the
// result slot is taken; the CRC byte step and status decode are
// combinational between the input register and the result register. A
// result is loaded as its final byte leaves the input register.
// Reset clears all frame state and both valid flags.
// A stalled result holds only a final byte in the input register; other
// bytes keep flowing.
`default_nettype none

module setting_detail_response_parser #(
  parameter int unsigned MAX_FRAME = sdrp_pkg::MaxFrameDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_in_frame
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [2:0] status, [3] crc_ok,
                                             // [11:4] setting_kind,
                                             // [19:12] size_limit,
                                             // [25:20] frame_length, rest zero
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_ready;
  logic              advance;
  sdrp_pkg::result_t result;

  // Move the held byte on unless it is final and the result slot is taken
  assign advance         = in_valid_q && (!in_last_q || out_ready);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  sdrp_frame_state #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  sdrp_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && in_last_q),
    .result_i        (result),
    .ready_o         (out_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  // Status is always one of the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= sdrp_pkg::StatusNoSize))
    else $error("status code out of range");

  // Size is reported only for a good frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[2:0] != sdrp_pkg::StatusOk))
      |-> (m_axis_tdata_o[19:12] == 8'h00))
    else $error("size_limit set on failed frame");

  // Length never passes the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((MAX_FRAME >= 64) || (m_axis_tdata_o[25:20] <= 6'(MAX_FRAME))))
    else $error("frame_length beyond buffer size");

  // A final byte blocked by a full result slot holds in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && m_axis_tvalid_o && !m_axis_tready_i)
      |=> (in_valid_q && in_last_q))
    else $error("final byte lost while result stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/sdrp_frame_state.sv
// Per-frame tracking state and result decode for the response parser.
// Depends on sdrp_pkg (constants, crc8_step, result_t).
`default_nettype none

module sdrp_frame_state #(
  parameter int unsigned MAX_FRAME = sdrp_pkg::MaxFrameDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  output sdrp_pkg::result_t     result_o
);

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    crc_all_q, crc_all_d;
  logic [7:0]    crc_prev_q, crc_prev_d;
  logic [7:0]    latest_q, latest_d;
  logic          header_q, header_d;
  logic [7:0]    kind_q, kind_d;
  logic          term_found_q, term_found_d;
  logic [CW-1:0] term_idx_q, term_idx_d;
  logic [7:0]    size_q, size_d;
  logic          size_seen_q, size_seen_d;

  logic          keep;
  logic [CW:0]   term_next;
  logic [CW:0]   n_less_one;
  logic [CW+5:0] len_ext;
  logic [2:0]    status;

  // Update the tracking values for one byte; drop bytes past the buffer size
  always_comb begin
    keep         = (cnt_q < CW'(MAX_FRAME));
    term_next    = {1'b0, term_idx_q} + (CW+1)'(1);
    cnt_d        = cnt_q;
    crc_all_d    = crc_all_q;
    crc_prev_d   = crc_prev_q;
    latest_d     = latest_q;
    header_d     = header_q;
    kind_d       = kind_q;
    term_found_d = term_found_q;
    term_idx_d   = term_idx_q;
    size_d       = size_q;
    size_seen_d  = size_seen_q;
    if (keep) begin
      crc_prev_d = crc_all_q;
      crc_all_d  = sdrp_pkg::crc8_step(crc_all_q, byte_i);
      latest_d   = byte_i;
      if (cnt_q == '0) begin
        header_d = (byte_i == sdrp_pkg::FrameHeader);
      end
      if (cnt_q == CW'(sdrp_pkg::KindIndex)) begin
        kind_d = byte_i;
      end
      if (term_found_q && !size_seen_q && ({1'b0, cnt_q} == term_next)) begin
        size_d      = byte_i;
        size_seen_d = 1'b1;
      end
      if ((cnt_q >= CW'(sdrp_pkg::TermStartIndex)) && !term_found_q && (byte_i == 8'h00)) begin
        term_found_d = 1'b1;
        term_idx_d   = cnt_q;
      end
      cnt_d = cnt_q + CW'(1);
    end
  end

  // Decode the result from the values after this byte
  always_comb begin
    n_less_one = {1'b0, cnt_d} - (CW+1)'(1);
    len_ext    = {6'b0, cnt_d};
    if (cnt_d < CW'(sdrp_pkg::MinLen)) begin
      status = sdrp_pkg::StatusTooShort;
    end else if (!header_d) begin
      status = sdrp_pkg::StatusBadHeader;
    end else if (kind_d != sdrp_pkg::TypeString) begin
      status = sdrp_pkg::StatusNotString;
    end else if (!term_found_d || ({1'b0, term_idx_d} >= n_less_one)) begin
      status = sdrp_pkg::StatusNoTerm;
    end else if (!size_seen_d || (({1'b0, term_idx_d} + (CW+1)'(1)) >= n_less_one)) begin
      status = sdrp_pkg::StatusNoSize;
    end else begin
      status = sdrp_pkg::StatusOk;
    end
    result_o.status       = status;
    result_o.crc_ok       = (cnt_d != '0) && (latest_d == crc_prev_d);
    result_o.setting_kind = kind_d;
    result_o.size_limit   = (status == sdrp_pkg::StatusOk) ? size_d : 8'h00;
    result_o.frame_length = len_ext[5:0];
  end

  // Advance on each byte; start fresh after the final one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      crc_all_q    <= '0;
      crc_prev_q   <= '0;
      latest_q     <= '0;
      header_q     <= 1'b0;
      kind_q       <= '0;
      term_found_q <= 1'b0;
      term_idx_q   <= '0;
      size_q       <= '0;
      size_seen_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q        <= '0;
        crc_all_q    <= '0;
        crc_prev_q   <= '0;
        latest_q     <= '0;
        header_q     <= 1'b0;
        kind_q       <= '0;
        term_found_q <= 1'b0;
        term_idx_q   <= '0;
        size_q       <= '0;
        size_seen_q  <= 1'b0;
      end else begin
        cnt_q        <= cnt_d;
        crc_all_q    <= crc_all_d;
        crc_prev_q   <= crc_prev_d;
        latest_q     <= latest_d;
        header_q     <= header_d;
        kind_q       <= kind_d;
        term_found_q <= term_found_d;
        term_idx_q   <= term_idx_d;
        size_q       <= size_d;
        size_seen_q  <= size_seen_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sdrp_out_reg.sv
// Result register of the response parser, driving the master-side stream.
// Depends on sdrp_pkg (result_t).
`default_nettype none

module sdrp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire sdrp_pkg::result_t result_i,
  output logic                   ready_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [31:0]            m_axis_tdata_o
);

  logic              valid_q;
  sdrp_pkg::result_t data_q;

  // Free when empty or when the held result transfers this cycle
  assign ready_o = !valid_q || m_axis_tready_i;

  // Hold valid until the result transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {6'b0, data_q};

endmodule

`default_nettype wire
